// ----- sv/gb5_pkg.sv -----
// ============================================================================
// gb5_pkg
// Shared constants, codes and types of the streaming 5x5 Gaussian blur.
// ============================================================================
`default_nettype none

package gb5_pkg;

   // Frame geometry and pixel format.
   localparam int MAX_WIDTH    = 1024;
   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int PIXEL_BITS   = 8;
   localparam int WIDTH_BITS   = 11;
   localparam int HEIGHT_BITS  = 13;
   localparam int ROW_BITS     = HEIGHT_BITS + 1;
   localparam int MIN_DIM      = 3;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   // Line store: four previous rows, each in its own slot.
   localparam int SLOTS     = 4;
   localparam int SLOT_BITS = 2;

   // Kernel and result format.
   localparam int TAPS      = 5;
   localparam int VSUM_BITS = PIXEL_BITS + 4;
   localparam int BLUR_BITS = 16;

   // Result queue.
   localparam int BURST         = 3;
   localparam int PUSH_BITS     = 2;
   localparam int FIFO_DEPTH    = 16;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

   // Configuration port.
   localparam int CSR_IDX_BITS  = 8;
   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_IMAGE_WIDTH  = 8'd0,
      REG_IMAGE_HEIGHT = 8'd1
   } csr_reg_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [VSUM_BITS-1:0]  vsum_type;
   typedef logic [BLUR_BITS-1:0]  blur_type;

   // One accepted item after the first register.
   typedef struct packed {
      pixel_type             cur;
      logic [SLOT_BITS-1:0]  slot;
      logic [SLOTS-1:0]      row_ok;
      logic                  first;
      logic                  emit;
      logic                  row_end;
      logic                  last;
   } item_type;

   // Access of the line store for one accepted item.
   typedef struct packed {
      logic                 en;
      logic [COL_BITS-1:0]  addr;
      logic [SLOT_BITS-1:0] slot;
      pixel_type            data;
   } store_cmd_type;

   typedef struct packed {
      blur_type blurred;
      logic     last;
   } result_type;

   // Up to three results written to the queue in one cycle.
   typedef struct packed {
      logic [PUSH_BITS-1:0]    count;
      result_type [BURST-1:0]  data;
   } push_type;

endpackage

`default_nettype wire

// ----- sv/gb5_req_if.sv -----
// ============================================================================
// gb5_req_if
// Input pixel channel: valid/ready handshake with operation and pixel.
// ============================================================================
`default_nettype none

interface gb5_req_if;
   logic                            valid;
   logic                            ready;
   logic                            operation;
   logic [gb5_pkg::PIXEL_BITS-1:0]  pixel;

   modport source (output valid, output operation, output pixel, input ready);
   modport sink   (input valid, input operation, input pixel, output ready);
endinterface

`default_nettype wire

// ----- sv/gb5_rsp_if.sv -----
// ============================================================================
// gb5_rsp_if
// Result channel: valid/ready handshake with the blurred pixel and frame end.
// ============================================================================
`default_nettype none

interface gb5_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [gb5_pkg::BLUR_BITS-1:0]  blurred;
   logic                           last;

   modport source (output valid, output blurred, output last, input ready);
   modport sink   (input valid, input blurred, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/gb5_csr_if.sv -----
// ============================================================================
// gb5_csr_if
// Configuration write channel: valid/ready handshake with index and data.
// ============================================================================
`default_nettype none

interface gb5_csr_if;
   logic                               valid;
   logic                               ready;
   logic [gb5_pkg::CSR_IDX_BITS-1:0]   index;
   logic [gb5_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/gb5_ctrl.sv -----
// ============================================================================
// gb5_ctrl
// Configuration registers, raster counters, result reservation and the
// input register of the pipeline.
// ============================================================================
`default_nettype none

module gb5_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   gb5_req_if.sink                                req_if,
   gb5_csr_if.sink                                csr_if,
   input  wire logic                              rsp_pop,
   output gb5_pkg::store_cmd_type                 store_cmd,
   output gb5_pkg::item_type                      item,
   output logic                                   item_valid,
   output logic [gb5_pkg::FIFO_CNT_BITS-1:0]      reserve
);
   import gb5_pkg::*;

   logic [WIDTH_BITS-1:0]    width_ff, width_in;
   logic [HEIGHT_BITS-1:0]   height_ff, height_in;
   logic [COL_BITS-1:0]      col_ff, col_in;
   logic [ROW_BITS-1:0]      row_ff, row_in;
   logic [FIFO_CNT_BITS-1:0] reserve_ff, reserve_in;
   item_type                 item_ff, item_in;
   logic                     item_valid_ff, item_valid_in;

   logic [COL_BITS-1:0]      col_last;
   logic [ROW_BITS-1:0]      eff_h;
   logic [ROW_BITS-1:0]      h_plus1;
   logic                     fire;
   logic                     csr_fire;
   logic                     at_col_last;
   logic                     emit;
   pixel_type                cur;
   logic [PUSH_BITS-1:0]     n_new;

   // Effective frame size: width clamped to [3, MAX_WIDTH], height to at least 3.
   always_comb begin
      if (width_ff < WIDTH_BITS'(MIN_DIM)) begin
         col_last = COL_BITS'(MIN_DIM - 1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         col_last = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         col_last = COL_BITS'(width_ff - WIDTH_BITS'(1));
      end
      eff_h   = (height_ff < HEIGHT_BITS'(MIN_DIM)) ? ROW_BITS'(MIN_DIM)
                                                    : ROW_BITS'(height_ff);
      h_plus1 = eff_h + ROW_BITS'(1);
   end

   // Handshakes. Input is held off while the queue could not take a full burst.
   assign fire          = req_if.valid && req_if.ready;
   assign csr_fire      = csr_if.valid && csr_if.ready;
   assign req_if.ready  = (reserve_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - BURST));
   assign csr_if.ready  = 1'b1;

   // Decode of the item at the current raster position.
   always_comb begin
      at_col_last = (col_ff == col_last);
      emit        = (row_ff >= ROW_BITS'(2)) && (col_ff >= COL_BITS'(2));
      // Flush items and pixels of the padding rows count as zero.
      if (req_if.operation == OP_PIXEL && row_ff < eff_h) begin
         cur = req_if.pixel;
      end else begin
         cur = '0;
      end
      if (!emit) begin
         n_new = '0;
      end else if (at_col_last) begin
         n_new = PUSH_BITS'(BURST);
      end else begin
         n_new = PUSH_BITS'(1);
      end

      item_in.cur     = cur;
      item_in.slot    = row_ff[SLOT_BITS-1:0];
      for (int k = 0; k < SLOTS; k++) begin
         // Row slot k holds input row row_ff-(SLOTS-k); rows above the top are zero.
         item_in.row_ok[k] = (row_ff >= ROW_BITS'(SLOTS - k));
      end
      item_in.first   = (col_ff == '0);
      item_in.emit    = emit;
      item_in.row_end = at_col_last;
      item_in.last    = (row_ff == h_plus1);
      item_valid_in   = fire;
   end

   // Line store access happens as the item is taken.
   always_comb begin
      store_cmd.en   = fire;
      store_cmd.addr = col_ff;
      store_cmd.slot = row_ff[SLOT_BITS-1:0];
      store_cmd.data = cur;
   end

   // Registers, counters and reservation bookkeeping.
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      reserve_in = reserve_ff + FIFO_CNT_BITS'(fire ? n_new : '0)
                   - FIFO_CNT_BITS'(rsp_pop);
      if (csr_fire) begin
         case (csr_reg_type'(csr_if.index))
            REG_IMAGE_WIDTH: begin
               width_in = csr_if.data[WIDTH_BITS-1:0];
               col_in   = '0;
               row_in   = '0;
            end
            REG_IMAGE_HEIGHT: begin
               height_in = csr_if.data[HEIGHT_BITS-1:0];
               col_in    = '0;
               row_in    = '0;
            end
            default: begin
            end
         endcase
      end else if (fire) begin
         if (at_col_last) begin
            col_in = '0;
            row_in = (row_ff >= h_plus1) ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_BITS'(WIDTH_RESET);
         height_ff     <= HEIGHT_BITS'(HEIGHT_RESET);
         col_ff        <= '0;
         row_ff        <= '0;
         reserve_ff    <= '0;
         item_valid_ff <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         reserve_ff    <= reserve_in;
         item_valid_ff <= item_valid_in;
      end
   end

   // Item payload register.
   always_ff @(posedge clock) begin
      if (fire) begin
         item_ff <= item_in;
      end
   end

   assign item       = item_ff;
   assign item_valid = item_valid_ff;
   assign reserve    = reserve_ff;

endmodule

`default_nettype wire

// ----- sv/gb5_line_store.sv -----
// ============================================================================
// gb5_line_store
// Four row memories of MAX_WIDTH pixels, read at the item's column and
// written in the current row's slot, with registered read data.
// ============================================================================
`default_nettype none

module gb5_line_store (
   input  wire logic                                 clock,
   input  wire gb5_pkg::store_cmd_type               cmd,
   output gb5_pkg::pixel_type [gb5_pkg::SLOTS-1:0]   rd_data
);
   import gb5_pkg::*;

   for (genvar s = 0; s < SLOTS; s++) begin : g_slot
      pixel_type mem [MAX_WIDTH];
      pixel_type rd_ff;

      // Read returns the old content where the same column is written.
      always_ff @(posedge clock) begin
         if (cmd.en) begin
            rd_ff <= mem[cmd.addr];
            if (cmd.slot == SLOT_BITS'(s)) begin
               mem[cmd.addr] <= cmd.data;
            end
         end
      end

      assign rd_data[s] = rd_ff;
   end

endmodule

`default_nettype wire

// ----- sv/gb5_filter.sv -----
// ============================================================================
// gb5_filter
// Separable kernel: vertical 1-4-6-4-1 sum of the new column into a window
// of five column sums, then horizontal sums for one or three results.
// ============================================================================
`default_nettype none

module gb5_filter (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 item_valid,
   input  wire gb5_pkg::item_type                    item,
   input  wire gb5_pkg::pixel_type [gb5_pkg::SLOTS-1:0] rd_data,
   output gb5_pkg::push_type                         push,
   output logic                                      busy
);
   import gb5_pkg::*;

   // Weighted 1-4-6-4-1 sum of five pixels.
   function automatic vsum_type col_sum(input pixel_type p0, input pixel_type p1,
                                        input pixel_type p2, input pixel_type p3,
                                        input pixel_type p4);
      vsum_type a0, a1, a2, a3, a4;
      a0 = VSUM_BITS'(p0);
      a1 = VSUM_BITS'(p1);
      a2 = VSUM_BITS'(p2);
      a3 = VSUM_BITS'(p3);
      a4 = VSUM_BITS'(p4);
      return a0 + (a1 << 2) + (a2 << 2) + (a2 << 1) + (a3 << 2) + a4;
   endfunction

   // Weighted 1-4-6-4-1 sum of five column sums.
   function automatic blur_type row_sum(input vsum_type v0, input vsum_type v1,
                                        input vsum_type v2, input vsum_type v3,
                                        input vsum_type v4);
      blur_type b0, b1, b2, b3, b4;
      b0 = BLUR_BITS'(v0);
      b1 = BLUR_BITS'(v1);
      b2 = BLUR_BITS'(v2);
      b3 = BLUR_BITS'(v3);
      b4 = BLUR_BITS'(v4);
      return b0 + (b1 << 2) + (b2 << 2) + (b2 << 1) + (b3 << 2) + b4;
   endfunction

   pixel_type col [TAPS];
   vsum_type  v_new;
   vsum_type  win_ff [TAPS];
   vsum_type  win_in [TAPS];
   logic      valid_ff, valid_in;
   logic      emit_ff, row_end_ff, last_ff;
   blur_type  sum0, sum1, sum2;

   // New column: four stored rows, masked above the top, and the current pixel.
   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         col[k] = item.row_ok[k] ? rd_data[item.slot + SLOT_BITS'(k)] : '0;
      end
      col[TAPS-1] = item.cur;
      v_new = col_sum(col[0], col[1], col[2], col[3], col[4]);
   end

   // Window shift; the first column of a row starts from an empty window.
   always_comb begin
      for (int j = 0; j < TAPS - 1; j++) begin
         win_in[j] = item.first ? '0 : win_ff[j + 1];
      end
      win_in[TAPS-1] = v_new;
      valid_in = item_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid) begin
         win_ff     <= win_in;
         emit_ff    <= item.emit;
         row_end_ff <= item.row_end;
         last_ff    <= item.last;
      end
   end

   // Result sums; at a row end two zero columns follow the last one.
   always_comb begin
      sum0 = row_sum(win_ff[0], win_ff[1], win_ff[2], win_ff[3], win_ff[4]);
      sum1 = row_sum(win_ff[1], win_ff[2], win_ff[3], win_ff[4], '0);
      sum2 = row_sum(win_ff[2], win_ff[3], win_ff[4], '0, '0);

      if (!valid_ff || !emit_ff) begin
         push.count = '0;
      end else if (row_end_ff) begin
         push.count = PUSH_BITS'(BURST);
      end else begin
         push.count = PUSH_BITS'(1);
      end
      push.data[0].blurred = sum0;
      push.data[0].last    = 1'b0;
      push.data[1].blurred = sum1;
      push.data[1].last    = 1'b0;
      push.data[2].blurred = sum2;
      push.data[2].last    = last_ff;
   end

   assign busy = valid_ff;

endmodule

`default_nettype wire

// ----- sv/gb5_out_fifo.sv -----
// ============================================================================
// gb5_out_fifo
// Result queue that takes up to three results a cycle and hands out one.
// ============================================================================
`default_nettype none

module gb5_out_fifo (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire gb5_pkg::push_type                  push,
   gb5_rsp_if.source                               rsp_if,
   output logic [gb5_pkg::FIFO_CNT_BITS-1:0]       count
);
   import gb5_pkg::*;

   result_type               entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ff, wr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ff, rd_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     pop;

   assign pop = rsp_if.valid && rsp_if.ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_in    = wr_ff + FIFO_PTR_BITS'(push.count);
      rd_in    = rd_ff + FIFO_PTR_BITS'(pop);
      count_in = count_ff + FIFO_CNT_BITS'(push.count) - FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Burst write at consecutive places.
   always_ff @(posedge clock) begin
      for (int k = 0; k < BURST; k++) begin
         if (PUSH_BITS'(k) < push.count) begin
            entry_ff[wr_ff + FIFO_PTR_BITS'(k)] <= push.data[k];
         end
      end
   end

   // Head of the queue drives the result channel.
   assign rsp_if.valid   = (count_ff != '0);
   assign rsp_if.blurred = entry_ff[rd_ff].blurred;
   assign rsp_if.last    = entry_ff[rd_ff].last;
   assign count          = count_ff;

endmodule

`default_nettype wire

// ----- sv/gaussian_blur_5x5_top.sv -----
// ============================================================================
// gaussian_blur_5x5_top
// Streaming 5x5 binomial Gaussian blur with two pixels of zero padding.
// ============================================================================
// Pixels enter on req_if in raster order (operation 0 = pixel, 1 = flush).
// After a frame, 2*width flush items drain the last two output rows.
// Results leave on rsp_if as unsigned 8.8 fixed point; last marks the final
// result of the frame. csr_if writes image_width (index 0) and image_height
// (index 1); either write restarts the frame. Write only while idle.
// Throughput: one pixel per cycle while req_if.ready is high. An item yields
// no result, one result, or three at the end of a row; the result channel
// gives one per cycle while the receiver is ready. A result passes these
// registers after its item is taken: line store read with the item register,
// column sum into the window, row sums into the queue; it is then valid on rsp_if.
// A 16-entry result queue absorbs row-end bursts. req_if.ready drops while
// more than 13 results are queued or still in the pipeline, so a stalled
// receiver holds the input off and no result is lost.
// Reset loads 640x480 and clears the counters; the line store needs no
// clearing pass since rows above the top are masked by the row counter.
// ============================================================================
`default_nettype none

module gaussian_blur_5x5_top (
   input  wire logic   clock,
   input  wire logic   reset,
   gb5_req_if.sink     req_if,
   gb5_rsp_if.source   rsp_if,
   gb5_csr_if.sink     csr_if
);
   import gb5_pkg::*;

   store_cmd_type                store_cmd;
   item_type                     item;
   logic                         item_valid;
   logic [FIFO_CNT_BITS-1:0]     reserve;
   logic [FIFO_CNT_BITS-1:0]     fifo_count;
   pixel_type [SLOTS-1:0]        rd_data;
   push_type                     push;
   logic                         filter_busy;
   logic                         rsp_pop;

   assign rsp_pop = rsp_if.valid && rsp_if.ready;

   // Counters, configuration and input register.
   gb5_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_if     (csr_if),
      .rsp_pop    (rsp_pop),
      .store_cmd  (store_cmd),
      .item       (item),
      .item_valid (item_valid),
      .reserve    (reserve)
   );

   // Four previous rows.
   gb5_line_store u_line_store (
      .clock   (clock),
      .cmd     (store_cmd),
      .rd_data (rd_data)
   );

   // Column sums, window and row sums.
   gb5_filter u_filter (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .rd_data    (rd_data),
      .push       (push),
      .busy       (filter_busy)
   );

   // Result queue.
   gb5_out_fifo u_out_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .rsp_if (rsp_if),
      .count  (fifo_count)
   );

   // Reservation always covers what the queue holds.
   a_queue_covered: assert property (@(posedge clock) disable iff (reset)
      fifo_count <= reserve)
      else $error("result queue holds more than was reserved");

   // Reservation never exceeds the queue.
   a_reserve_bound: assert property (@(posedge clock) disable iff (reset)
      reserve <= FIFO_CNT_BITS'(FIFO_DEPTH))
      else $error("result reservation exceeds queue depth");

   // With the pipeline empty, every reserved result sits in the queue.
   a_pipe_drained: assert property (@(posedge clock) disable iff (reset)
      (!item_valid && !filter_busy) |-> (fifo_count == reserve))
      else $error("reserved results missing with pipeline empty");

endmodule

`default_nettype wire
